>>> design/tpcc_pkg.sv
// Shared types and constants for the three-phase current conditioner.
// Used by every module in the design folder but tpcc_ram; no dependencies.
package tpcc_pkg;

  // Field widths fixed by the interface
  localparam int CUR_W  = 17;
  localparam int TOT_OW = 19;
  localparam int OFF_W  = 15;
  localparam int MSK_W  = 3;

  // Shared multiplier operand widths
  localparam int MUL_AW = 17;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Q16 coefficients
  localparam logic [MUL_BW-1:0] NF_KEEP    = 16'd64553;
  localparam logic [MUL_BW-1:0] NF_TAKE    = 16'd983;
  localparam logic [MUL_BW-1:0] ALPHA_UP   = 16'd11796;
  localparam logic [MUL_BW-1:0] ALPHA_DOWN = 16'd5898;
  localparam logic [31:0]       Q16_HALF   = 32'd32768;

  localparam logic [CUR_W-1:0] CUR_MAX   = 17'd131071;
  localparam logic [31:0]      TOTAL_MAX = 32'd524287;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_MASK    = 3'd0,
    REG_OFF_A   = 3'd1,
    REG_OFF_B   = 3'd2,
    REG_OFF_C   = 3'd3,
    REG_LOW_LIM = 3'd4,
    REG_MID_LIM = 3'd5,
    REG_LOW_OFF = 3'd6,
    REG_MID_OFF = 3'd7
  } reg_idx_e;

  localparam logic [MSK_W-1:0] RST_MASK    = 3'd7;
  localparam logic [CUR_W-1:0] RST_LOW_LIM = 17'd10240;
  localparam logic [CUR_W-1:0] RST_MID_LIM = 17'd30720;
  localparam logic [OFF_W-1:0] RST_MID_OFF = 15'd1024;

  typedef struct packed {
    logic [MSK_W-1:0]           mask;
    logic [2:0][OFF_W-1:0]      phase_off;
    logic [CUR_W-1:0]           low_lim;
    logic [CUR_W-1:0]           mid_lim;
    logic [OFF_W-1:0]           low_off;
    logic [OFF_W-1:0]           mid_off;
  } cfg_t;

  // One per-phase entry of the state memory
  typedef struct packed {
    logic [CUR_W-1:0] noise;
    logic             active;
    logic [CUR_W-1:0] smooth;
    logic [CUR_W-1:0] rep;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_NF2,
    S_NF3,
    S_EMA,
    S_FLT,
    S_WB
  } state_e;

  // Thousandths of an amp to the nearest Q code
  function automatic logic [31:0] q_of_ma(input int unsigned fb, input int unsigned ma);
    int unsigned v;
    v = ((ma << fb) + 500) / 1000;
    return 32'(v);
  endfunction

endpackage

>>> design/tpcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tpcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tpcc_mul.sv
// Shared 17x16 unsigned multiplier with registered product.
// Depends on tpcc_pkg for operand widths.
module tpcc_mul (
  input  logic                      clk_i,
  input  logic [tpcc_pkg::MUL_AW-1:0] a_i,
  input  logic [tpcc_pkg::MUL_BW-1:0] b_i,
  output logic [tpcc_pkg::MUL_PW-1:0] p_o
);
  import tpcc_pkg::*;

  logic [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> design/tpcc_cfg_regs.sv
// APB-style configuration registers of the current conditioner.
// Depends on tpcc_pkg for the register map and the cfg_t bundle.
module tpcc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tpcc_pkg::CFG_AW-1:0] paddr,
  input  logic [tpcc_pkg::CFG_DW-1:0] pwdata,
  output logic [tpcc_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output tpcc_pkg::cfg_t            cfg_o
);
  import tpcc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes, masked to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask      <= RST_MASK;
      cfg_q.phase_off <= '0;
      cfg_q.low_lim   <= RST_LOW_LIM;
      cfg_q.mid_lim   <= RST_MID_LIM;
      cfg_q.low_off   <= '0;
      cfg_q.mid_off   <= RST_MID_OFF;
    end else if (wr) begin
      unique case (idx)
        REG_MASK:    cfg_q.mask         <= pwdata[MSK_W-1:0];
        REG_OFF_A:   cfg_q.phase_off[0] <= pwdata[OFF_W-1:0];
        REG_OFF_B:   cfg_q.phase_off[1] <= pwdata[OFF_W-1:0];
        REG_OFF_C:   cfg_q.phase_off[2] <= pwdata[OFF_W-1:0];
        REG_LOW_LIM: cfg_q.low_lim      <= pwdata[CUR_W-1:0];
        REG_MID_LIM: cfg_q.mid_lim      <= pwdata[CUR_W-1:0];
        REG_LOW_OFF: cfg_q.low_off      <= pwdata[OFF_W-1:0];
        REG_MID_OFF: cfg_q.mid_off      <= pwdata[OFF_W-1:0];
        default:     ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_MASK:    prdata = CFG_DW'(cfg_q.mask);
      REG_OFF_A:   prdata = CFG_DW'(cfg_q.phase_off[0]);
      REG_OFF_B:   prdata = CFG_DW'(cfg_q.phase_off[1]);
      REG_OFF_C:   prdata = CFG_DW'(cfg_q.phase_off[2]);
      REG_LOW_LIM: prdata = CFG_DW'(cfg_q.low_lim);
      REG_MID_LIM: prdata = CFG_DW'(cfg_q.mid_lim);
      REG_LOW_OFF: prdata = CFG_DW'(cfg_q.low_off);
      REG_MID_OFF: prdata = CFG_DW'(cfg_q.mid_off);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/three_phase_current_conditioner_top.sv
// Top level of the three-phase current conditioner: sequencer and datapath.
// Depends on tpcc_pkg, tpcc_ram, tpcc_mul and tpcc_cfg_regs.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / raw_rms_i) carries one raw RMS
//   reading per transfer; readings go to phases 0, 1, .. NUM_PHASES-1 in turn.
//   Output channel (out_valid_o / out_stall_i) carries one result per input:
//   phase id, conditioned phase current, three-phase total and active flag.
//   Per-phase state lives in one small RAM with a registered read. Each item
//   is read, run through the shared 17x16 multiplier three times (noise floor
//   twice, EMA once) and written back. After its input transfer an item steps
//   through S_RD, S_NF2, S_NF3, S_EMA, S_FLT and S_WB; S_WB stores the result.
//   The input stays stalled until write-back, so reads never overlap a write
//   to the same entry.
//   A pending result sits in an output register; the next item is accepted and
//   processed meanwhile, and waits in write-back if the result is still held.
//   Reset clears the phase counter, the running total, the output valid flag
//   and the per-entry valid bits, so every phase reads back as zero state. No
//   clearing pass is needed. Configuration is an APB-style port with no wait
//   states, pready always high.
module three_phase_current_conditioner_top #(
  parameter int NUM_PHASES = 3,
  parameter int FRAC_BITS  = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tpcc_pkg::CUR_W-1:0]  raw_rms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  phase_id_o,
  output logic [tpcc_pkg::CUR_W-1:0]  phase_current_o,
  output logic [tpcc_pkg::TOT_OW-1:0] total_current_o,
  output logic                        phase_on_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpcc_pkg::CFG_AW-1:0] paddr,
  input  logic [tpcc_pkg::CFG_DW-1:0] pwdata,
  output logic [tpcc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import tpcc_pkg::*;

  localparam int PW    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int TOT_W = CUR_W + $clog2(NUM_PHASES);
  localparam int EW    = $bits(entry_t);

  // Thresholds in Q(FRAC_BITS)
  localparam logic [31:0] TH_NF  = q_of_ma(FRAC_BITS, 2200);
  localparam logic [31:0] TH_OFS = q_of_ma(FRAC_BITS, 150);
  localparam logic [31:0] TH_ON  = q_of_ma(FRAC_BITS, 1000);
  localparam logic [31:0] TH_OFF = q_of_ma(FRAC_BITS, 450);
  localparam logic [31:0] TH_MIN = q_of_ma(FRAC_BITS, 80);

  cfg_t cfg;

  tpcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control state
  state_e                state_q, state_d;
  logic [PW-1:0]         phase_q;
  logic [NUM_PHASES-1:0] valid_q;
  logic                  rd_valid_q;
  logic                  out_valid_q;
  logic [TOT_W-1:0]      total_q;

  // Payload registers
  logic [CUR_W-1:0]  raw_q;
  logic              en_q;
  entry_t            ent_q;
  logic [MUL_PW-1:0] acc_q;
  logic [CUR_W-1:0]  nf_q;
  logic [CUR_W-1:0]  corr_q;
  logic              act_q;
  logic              rising_q;
  logic [CUR_W-1:0]  filt_q;
  logic [1:0]        out_id_q;
  logic [CUR_W-1:0]  out_cur_q;
  logic [TOT_OW-1:0] out_tot_q;
  logic              out_on_q;

  // Sequencer outputs
  logic              accept;
  logic              go;
  logic              ram_re;
  logic              ram_we;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;

  logic [EW-1:0]     ram_rdata;
  entry_t            rd_ent;
  entry_t            wb_ent;
  logic [MUL_PW-1:0] mul_p;

  tpcc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_PHASES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phase_q),
    .wdata_i (wb_ent),
    .re_i    (ram_re),
    .raddr_i (phase_q),
    .rdata_o (ram_rdata)
  );

  tpcc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Entries never written read as zero state
  assign rd_ent = rd_valid_q ? entry_t'(ram_rdata) : '0;

  // Result register free or being emptied
  assign go = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD;
      S_RD:   state_d = S_NF2;
      S_NF2:  state_d = S_NF3;
      S_NF3:  state_d = S_EMA;
      S_EMA:  state_d = S_FLT;
      S_FLT:  state_d = S_WB;
      S_WB:   if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM strobes, multiplier operands
  always_comb begin
    logic              rise;
    logic [CUR_W-1:0]  d;
    rise       = corr_q >= ent_q.smooth;
    d          = rise ? (corr_q - ent_q.smooth) : (ent_q.smooth - corr_q);
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i;
      end
      S_RD: begin
        mul_a = rd_ent.noise;
        mul_b = NF_KEEP;
      end
      S_NF2: begin
        mul_a = raw_q;
        mul_b = NF_TAKE;
      end
      S_EMA: begin
        mul_a = d;
        mul_b = rise ? ALPHA_UP : ALPHA_DOWN;
      end
      S_WB: ram_we = go;
      default: ;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // Phase enable and per-phase offset; phases past the third use defaults
  logic [2:0]       ph3;
  logic             ph_en;
  logic [OFF_W-1:0] ph_off;

  assign ph3 = 3'(phase_q);

  always_comb begin
    unique case (ph3)
      3'd0:    begin ph_en = cfg.mask[0]; ph_off = cfg.phase_off[0]; end
      3'd1:    begin ph_en = cfg.mask[1]; ph_off = cfg.phase_off[1]; end
      3'd2:    begin ph_en = cfg.mask[2]; ph_off = cfg.phase_off[2]; end
      default: begin ph_en = 1'b1;        ph_off = '0;               end
    endcase
  end

  // Noise floor update, floor subtraction and hysteresis
  logic [MUL_PW:0]   nf_sum;
  logic [CUR_W-1:0]  nf_new;
  logic signed [19:0] diff;
  logic [CUR_W-1:0]  corr;
  logic              act_new;

  always_comb begin
    nf_sum = {1'b0, acc_q} + {1'b0, mul_p} + (MUL_PW + 1)'(Q16_HALF);
    nf_new = (32'(raw_q) < TH_NF) ? nf_sum[MUL_AW + 15:16] : ent_q.noise;
    diff   = $signed({3'b0, raw_q}) - $signed({3'b0, nf_new}) - $signed(20'(TH_OFS));
    corr   = diff[19] ? '0 : diff[CUR_W-1:0];
    act_new = ent_q.active;
    if (!act_new && (32'(corr) >= TH_ON)) act_new = 1'b1;
    if (act_new && (32'(corr) <= TH_OFF)) act_new = 1'b0;
  end

  // EMA step and low-value cutoff
  logic [MUL_PW:0]  step_sum;
  logic [CUR_W-1:0] step;
  logic [CUR_W:0]   filt_raw;
  logic [CUR_W-1:0] filt;

  always_comb begin
    step_sum = {1'b0, mul_p} + (MUL_PW + 1)'(Q16_HALF);
    step     = step_sum[MUL_AW + 15:16];
    filt_raw = rising_q ? ({1'b0, ent_q.smooth} + {1'b0, step})
                        : ({1'b0, ent_q.smooth} - {1'b0, step});
    if (filt_raw > {1'b0, CUR_MAX}) filt = CUR_MAX;
    else                            filt = filt_raw[CUR_W-1:0];
    if (32'(filt) < TH_MIN) filt = '0;
  end

  // Band offset, phase offset, clamp; write-back entry and new total
  logic [CUR_W-1:0]   mid_eff;
  logic [OFF_W-1:0]   band;
  logic signed [19:0] v;
  logic [CUR_W-1:0]   rep_new;
  logic [TOT_W-1:0]   total_new;

  always_comb begin
    mid_eff = (cfg.mid_lim < cfg.low_lim) ? cfg.low_lim : cfg.mid_lim;
    priority if (filt_q == '0)          band = '0;
    else if (filt_q <= cfg.low_lim)     band = cfg.low_off;
    else if (filt_q <= mid_eff)         band = cfg.mid_off;
    else                                band = '0;
    v = $signed({3'b0, filt_q}) + $signed({{5{band[OFF_W-1]}}, band})
      + $signed({{5{ph_off[OFF_W-1]}}, ph_off});
    if (v < 0)                                rep_new = '0;
    else if (v > $signed({3'b0, CUR_MAX}))    rep_new = CUR_MAX;
    else                                      rep_new = v[CUR_W-1:0];
    if (!en_q) rep_new = '0;
    wb_ent.noise  = en_q ? nf_q : ent_q.noise;
    wb_ent.active = en_q && act_q;
    wb_ent.smooth = en_q ? filt_q : '0;
    wb_ent.rep    = rep_new;
    total_new = total_q - TOT_W'(ent_q.rep) + TOT_W'(rep_new);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_valid_q <= valid_q[phase_q];
      end
      if (ram_we) begin
        valid_q[phase_q] <= 1'b1;
        total_q          <= total_new;
        phase_q          <= (phase_q == PW'(NUM_PHASES - 1)) ? '0 : phase_q + 1'b1;
        out_valid_q      <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_rms_i;
      en_q  <= ph_en;
    end
    if (state_q == S_RD)  ent_q <= rd_ent;
    if (state_q == S_NF2) acc_q <= mul_p;
    if (state_q == S_NF3) begin
      nf_q   <= nf_new;
      act_q  <= act_new;
      corr_q <= act_new ? corr : '0;
    end
    if (state_q == S_EMA) rising_q <= corr_q >= ent_q.smooth;
    if (state_q == S_FLT) filt_q   <= filt;
    if (ram_we) begin
      out_id_q  <= 2'(phase_q);
      out_cur_q <= rep_new;
      out_tot_q <= (32'(total_new) > TOTAL_MAX) ? '1 : TOT_OW'(total_new);
      out_on_q  <= wb_ent.active;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_id_o      = out_id_q;
  assign phase_current_o = out_cur_q;
  assign total_current_o = out_tot_q;
  assign phase_on_o      = out_on_q;

`ifndef NO_ASSERTIONS
  // A write-back always leaves a result in the output register
  a_wb_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_valid_q)
    else $error("write-back without a pending result");

  // Without an input transfer the sequencer stays idle
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> state_q == S_IDLE)
    else $error("sequencer left idle without a transfer");

  // The phase counter moves only at write-back
  a_phase_moves_at_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ram_we |=> $stable(phase_q))
    else $error("phase counter moved outside write-back");

  // No RAM read is issued while an item is in flight
  a_no_read_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> !ram_re && !ram_we)
    else $error("RAM access overlaps an item in flight");
`endif

endmodule
